@@ sv/adu_pkg.sv @@
// Shared types, constants and arithmetic helpers of the Adam update block.
`default_nettype none
package adu_pkg;

  localparam int FRAC_BITS  = 24;
  localparam int IDX_W      = 12;
  localparam int NUM_PARAMS = 4096;
  localparam int VAL_W      = 32;
  localparam int WGT_W      = 25;
  localparam int ROOT_W     = 28;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int DEN_W      = ROOT_W + 1;
  localparam int MAG_W      = 56;
  localparam int OUT_FIFO_DEPTH = 128;

  localparam logic [WGT_W-1:0] UNIT = WGT_W'(1) << FRAC_BITS;
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] VAL_MAX = 64'sd2147483647;
  localparam logic signed [63:0] VAL_MIN = -64'sd2147483648;

  localparam logic [WGT_W-1:0] FIRST_DECAY_RST  = 25'd1677722;
  localparam logic [WGT_W-1:0] SECOND_DECAY_RST = 25'd16777;
  localparam logic [WGT_W-1:0] STEP_RATE_RST    = 25'd16777;
  localparam logic [WGT_W-1:0] EPS_FLOOR_RST    = 25'd1;

  typedef enum logic [1:0] {
    CFG_FIRST_DECAY  = 2'd0,
    CFG_SECOND_DECAY = 2'd1,
    CFG_STEP_RATE    = 2'd2,
    CFG_EPS_FLOOR    = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    REQ_INIT   = 1'b0,
    REQ_UPDATE = 1'b1
  } req_t;

  typedef struct packed {
    req_t              req;
    logic              clip;
    logic signed [31:0] p;
    logic              neg;
    logic [MAG_W-1:0]  mag;
  } sq_tag_t;

  typedef struct packed {
    req_t              req;
    logic              clip;
    logic signed [31:0] p;
    logic              neg;
  } div_tag_t;

  function automatic logic [WGT_W-1:0] unit_weight(input logic [WGT_W-1:0] r);
    return (r > UNIT) ? UNIT : r;
  endfunction

  function automatic logic signed [31:0] clamp_val(input logic signed [63:0] x);
    logic signed [31:0] res;
    if (x > VAL_MAX) res = 32'sh7FFF_FFFF;
    else if (x < VAL_MIN) res = 32'sh8000_0000;
    else res = x[31:0];
    return res;
  endfunction

  function automatic logic signed [31:0] blend(input logic signed [31:0] old_val,
                                               input logic signed [31:0] new_val,
                                               input logic [WGT_W-1:0]   w);
    logic signed [63:0] acc;
    acc = signed'(64'(UNIT - w)) * 64'(old_val) + signed'(64'(w)) * 64'(new_val) + HALF;
    acc = acc >>> FRAC_BITS;
    return clamp_val(acc);
  endfunction

endpackage
`default_nettype wire

@@ sv/adam_optimizer_update.sv @@
// Top level of the Adam optimizer update block: moment stores, pipeline, output queue.
//
// Usage: each input transaction carries req_type in in_tuser and param_index,
// param_value and gradient in in_tdata. REQ_INIT loads the two moment stores from
// the gradient and returns the parameter unchanged; REQ_UPDATE blends the moments
// with the decay weights and returns param - rate * m / (sqrt(v) + eps).
// One result transaction per input, in order, new_param on out_tdata and the
// saturated flag on out_tuser. The user must write the registers on the cfg
// channel only while idle; the block does not enforce it. One transaction is taken
// per cycle while in_tready is high, via the 28-stage sqrt and 56-stage divider.
// Moment stores are read one stage ahead of the blend; a write by the item just
// ahead is forwarded. After reset the weights take their default values and the
// stores are undefined until an init writes an entry. When out_tready is low,
// results collect in a 128-entry queue and in_tready falls once the queue plus
// the items in flight would exceed its room.
`default_nettype none
module adam_optimizer_update import adu_pkg::*; #(
  parameter int FIFO_DEPTH = OUT_FIFO_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [79:0]       in_tdata,   // param_index[11:0], param_value[43:12], gradient[75:44]
  input  wire logic              in_tuser,   // req_type
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [31:0]            out_tdata,  // new_param[31:0]
  output logic                   out_tuser,  // saturated
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [WGT_W-1:0]  cfg_data
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CAP   = FIFO_DEPTH + 2;
  localparam int OCC_W = $clog2(CAP + 1);
  localparam int ENT_W = VAL_W + 1;

  // configuration
  logic [WGT_W-1:0] first_decay_r, second_decay_r, step_rate_r, eps_floor_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_decay_r  <= FIRST_DECAY_RST;
      second_decay_r <= SECOND_DECAY_RST;
      step_rate_r    <= STEP_RATE_RST;
      eps_floor_r    <= EPS_FLOOR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FIRST_DECAY:  first_decay_r  <= cfg_data;
        CFG_SECOND_DECAY: second_decay_r <= cfg_data;
        CFG_STEP_RATE:    step_rate_r    <= cfg_data;
        CFG_EPS_FLOOR:    eps_floor_r    <= cfg_data;
        default:          first_decay_r  <= first_decay_r;
      endcase
    end
  end

  // stage 1: capture, square the gradient
  logic                    in_acc;
  logic signed [31:0]      in_g;
  logic                    s1_valid_r;
  req_t                    s1_req_r;
  logic [IDX_W-1:0]        s1_idx_r;
  logic signed [31:0]      s1_p_r, s1_g_r;
  logic signed [63:0]      s1_gg_r;

  assign in_acc = in_tvalid && in_tready;
  assign in_g   = signed'(in_tdata[75:44]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
    end
    s1_req_r <= req_t'(in_tuser);
    s1_idx_r <= in_tdata[11:0];
    s1_p_r   <= signed'(in_tdata[43:12]);
    s1_g_r   <= in_g;
    s1_gg_r  <= 64'(in_g) * 64'(in_g);
  end

  logic signed [63:0] sq_round;
  logic               sq_clip;
  logic signed [31:0] sq_val;

  always_comb begin
    sq_round = (s1_gg_r + HALF) >>> FRAC_BITS;
    sq_clip  = sq_round > VAL_MAX;
    sq_val   = sq_clip ? 32'sh7FFF_FFFF : sq_round[31:0];
  end

  // stage 2: moments read back, blend, write
  logic                    s2_valid_r;
  req_t                    s2_req_r;
  logic [IDX_W-1:0]        s2_idx_r;
  logic signed [31:0]      s2_p_r, s2_g_r, s2_sq_r;
  logic                    s2_clip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
    s2_req_r  <= s1_req_r;
    s2_idx_r  <= s1_idx_r;
    s2_p_r    <= s1_p_r;
    s2_g_r    <= s1_g_r;
    s2_sq_r   <= sq_val;
    s2_clip_r <= sq_clip;
  end

  logic signed [31:0] m_mem [NUM_PARAMS];
  logic signed [31:0] v_mem [NUM_PARAMS];
  logic signed [31:0] m_q_r, v_q_r;
  logic signed [31:0] m_new, v_new, m_old, v_old, v_bl;

  logic                    s3_valid_r;
  req_t                    s3_req_r;
  logic [IDX_W-1:0]        s3_idx_r;
  logic signed [31:0]      s3_m_r, s3_v_r, s3_p_r;
  logic                    s3_clip_r;
  logic                    fwd;

  always_ff @(posedge clk) begin
    if (s2_valid_r) begin
      m_mem[s2_idx_r] <= m_new;
    end
    m_q_r <= m_mem[s1_idx_r];
  end

  always_ff @(posedge clk) begin
    if (s2_valid_r) begin
      v_mem[s2_idx_r] <= v_new;
    end
    v_q_r <= v_mem[s1_idx_r];
  end

  always_comb begin
    fwd   = s3_valid_r && (s3_idx_r == s2_idx_r);
    m_old = fwd ? s3_m_r : m_q_r;
    v_old = fwd ? s3_v_r : v_q_r;
    v_bl  = blend(v_old, s2_sq_r, unit_weight(second_decay_r));
    if (s2_req_r == REQ_INIT) begin
      m_new = s2_g_r;
      v_new = s2_sq_r;
    end else begin
      m_new = blend(m_old, s2_g_r, unit_weight(first_decay_r));
      v_new = v_bl[31] ? 32'sd0 : v_bl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
    s3_req_r  <= s2_req_r;
    s3_idx_r  <= s2_idx_r;
    s3_m_r    <= m_new;
    s3_v_r    <= v_new;
    s3_p_r    <= s2_p_r;
    s3_clip_r <= s2_clip_r;
  end

  // stage 3: rate times |m|, root of v
  logic [31:0]      m_abs;
  sq_tag_t          sq_in_tag, sq_out_tag;
  logic             sq_out_valid;
  logic [ROOT_W-1:0] sq_root;

  always_comb begin
    m_abs             = s3_m_r[31] ? (~s3_m_r + 32'd1) : s3_m_r;
    sq_in_tag.req     = s3_req_r;
    sq_in_tag.clip    = s3_clip_r;
    sq_in_tag.p       = s3_p_r;
    sq_in_tag.neg     = s3_m_r[31];
    sq_in_tag.mag     = MAG_W'(unit_weight(step_rate_r)) * MAG_W'(m_abs);
  end

  adu_sqrt #(
    .RW    (ROOT_W),
    .TAG_W ($bits(sq_tag_t))
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s3_valid_r),
    .in_rad    ({s3_v_r, FRAC_BITS'(0)}),
    .in_tag    (sq_in_tag),
    .out_valid (sq_out_valid),
    .out_root  (sq_root),
    .out_tag   (sq_out_tag)
  );

  // divisor and rounded dividend
  logic [DEN_W-1:0] den_sum, den_fix;
  logic             d_valid_r;
  logic [DEN_W-1:0] d_den_r;
  logic [MAG_W-1:0] d_num_r;
  div_tag_t         d_tag_r;

  always_comb begin
    den_sum = DEN_W'(sq_root) + DEN_W'(eps_floor_r);
    den_fix = (den_sum == '0) ? DEN_W'(1) : den_sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else begin
      d_valid_r <= sq_out_valid;
    end
    d_den_r      <= den_fix;
    d_num_r      <= sq_out_tag.mag + MAG_W'(den_fix >> 1);
    d_tag_r.req  <= sq_out_tag.req;
    d_tag_r.clip <= sq_out_tag.clip;
    d_tag_r.p    <= sq_out_tag.p;
    d_tag_r.neg  <= sq_out_tag.neg;
  end

  logic             dv_out_valid;
  logic [MAG_W-1:0] dv_quot;
  div_tag_t         dv_tag;

  adu_div #(
    .QW    (MAG_W),
    .DW    (DEN_W),
    .TAG_W ($bits(div_tag_t))
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (d_valid_r),
    .in_num    (d_num_r),
    .in_den    (d_den_r),
    .in_tag    (d_tag_r),
    .out_valid (dv_out_valid),
    .out_quot  (dv_quot),
    .out_tag   (dv_tag)
  );

  // final step and saturation
  logic signed [63:0] step, diff;
  logic               res_clip;
  logic signed [31:0] res_val;
  logic               res_sat;

  always_comb begin
    step     = dv_tag.neg ? -signed'(64'(dv_quot)) : signed'(64'(dv_quot));
    diff     = 64'(dv_tag.p) - step;
    res_clip = (diff > VAL_MAX) || (diff < VAL_MIN);
    if (dv_tag.req == REQ_UPDATE) begin
      res_val = clamp_val(diff);
      res_sat = dv_tag.clip | res_clip;
    end else begin
      res_val = dv_tag.p;
      res_sat = dv_tag.clip;
    end
  end

  // output queue
  logic [ENT_W-1:0] q_mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   fcnt_r;
  logic [ENT_W-1:0] q_data_r;
  logic             q_valid_r;
  logic             out_valid_r;
  logic [ENT_W-1:0] out_ent_r;
  logic [OCC_W-1:0] occ_r;
  logic             push, pop, out_move, out_acc;

  always_comb begin
    push     = dv_out_valid;
    out_acc  = out_valid_r && out_tready;
    out_move = q_valid_r && (!out_valid_r || out_tready);
    pop      = (fcnt_r != '0) && (!q_valid_r || out_move);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= {res_sat, res_val};
    end
    if (pop) begin
      q_data_r <= q_mem[rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (out_move) begin
      out_ent_r <= q_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      fcnt_r      <= '0;
      q_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      occ_r       <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      fcnt_r <= fcnt_r + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
      if (pop) begin
        q_valid_r <= 1'b1;
      end else if (out_move) begin
        q_valid_r <= 1'b0;
      end
      if (out_move) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      occ_r <= occ_r + OCC_W'(in_acc) - OCC_W'(out_acc);
    end
  end

  assign in_tready  = occ_r < OCC_W'(CAP);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_ent_r[VAL_W-1:0];
  assign out_tuser  = out_ent_r[VAL_W];

endmodule
`default_nettype wire

@@ sv/adu_sqrt.sv @@
// Pipelined integer square root, one result bit per stage, with a carried tag.
`default_nettype none
module adu_sqrt import adu_pkg::*; #(
  parameter int RW    = ROOT_W,
  parameter int TAG_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [2*RW-1:0]   in_rad,
  input  wire logic [TAG_W-1:0]  in_tag,
  output logic                   out_valid,
  output logic [RW-1:0]          out_root,
  output logic [TAG_W-1:0]       out_tag
);

  logic              valid_r [RW];
  logic [RW+1:0]     rem_r   [RW];
  logic [RW-1:0]     root_r  [RW];
  logic [2*RW-1:0]   rad_r   [RW];
  logic [TAG_W-1:0]  tag_r   [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic              valid_prev;
    logic [RW+1:0]     rem_prev;
    logic [RW-1:0]     root_prev;
    logic [2*RW-1:0]   rad_prev;
    logic [TAG_W-1:0]  tag_prev;
    logic [RW+1:0]     rem_sh;
    logic [RW+1:0]     trial;

    if (k == 0) begin : g_first
      assign valid_prev = in_valid;
      assign rem_prev   = '0;
      assign root_prev  = '0;
      assign rad_prev   = in_rad;
      assign tag_prev   = in_tag;
    end else begin : g_next
      assign valid_prev = valid_r[k-1];
      assign rem_prev   = rem_r[k-1];
      assign root_prev  = root_r[k-1];
      assign rad_prev   = rad_r[k-1];
      assign tag_prev   = tag_r[k-1];
    end

    assign rem_sh = {rem_prev[RW-1:0], rad_prev[2*RW-1 -: 2]};
    assign trial  = {root_prev, 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else begin
        valid_r[k] <= valid_prev;
      end
      tag_r[k] <= tag_prev;
      rad_r[k] <= rad_prev << 2;
      if (rem_sh >= trial) begin
        rem_r[k]  <= rem_sh - trial;
        root_r[k] <= {root_prev[RW-2:0], 1'b1};
      end else begin
        rem_r[k]  <= rem_sh;
        root_r[k] <= {root_prev[RW-2:0], 1'b0};
      end
    end
  end

  assign out_valid = valid_r[RW-1];
  assign out_root  = root_r[RW-1];
  assign out_tag   = tag_r[RW-1];

endmodule
`default_nettype wire

@@ sv/adu_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with a carried tag.
`default_nettype none
module adu_div import adu_pkg::*; #(
  parameter int QW    = MAG_W,
  parameter int DW    = DEN_W,
  parameter int TAG_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [QW-1:0]     in_num,
  input  wire logic [DW-1:0]     in_den,
  input  wire logic [TAG_W-1:0]  in_tag,
  output logic                   out_valid,
  output logic [QW-1:0]          out_quot,
  output logic [TAG_W-1:0]       out_tag
);

  logic              valid_r [QW];
  logic [DW-1:0]     rem_r   [QW];
  logic [QW-1:0]     num_r   [QW];
  logic [QW-1:0]     quot_r  [QW];
  logic [DW-1:0]     den_r   [QW];
  logic [TAG_W-1:0]  tag_r   [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic              valid_prev;
    logic [DW-1:0]     rem_prev;
    logic [QW-1:0]     num_prev;
    logic [QW-1:0]     quot_prev;
    logic [DW-1:0]     den_prev;
    logic [TAG_W-1:0]  tag_prev;
    logic [DW:0]       rem_sh;

    if (k == 0) begin : g_first
      assign valid_prev = in_valid;
      assign rem_prev   = '0;
      assign num_prev   = in_num;
      assign quot_prev  = '0;
      assign den_prev   = in_den;
      assign tag_prev   = in_tag;
    end else begin : g_next
      assign valid_prev = valid_r[k-1];
      assign rem_prev   = rem_r[k-1];
      assign num_prev   = num_r[k-1];
      assign quot_prev  = quot_r[k-1];
      assign den_prev   = den_r[k-1];
      assign tag_prev   = tag_r[k-1];
    end

    assign rem_sh = {rem_prev, num_prev[QW-1]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else begin
        valid_r[k] <= valid_prev;
      end
      tag_r[k] <= tag_prev;
      den_r[k] <= den_prev;
      num_r[k] <= num_prev << 1;
      if (rem_sh >= {1'b0, den_prev}) begin
        rem_r[k]  <= DW'(rem_sh - {1'b0, den_prev});
        quot_r[k] <= {quot_prev[QW-2:0], 1'b1};
      end else begin
        rem_r[k]  <= DW'(rem_sh);
        quot_r[k] <= {quot_prev[QW-2:0], 1'b0};
      end
    end
  end

  assign out_valid = valid_r[QW-1];
  assign out_quot  = quot_r[QW-1];
  assign out_tag   = tag_r[QW-1];

endmodule
`default_nettype wire
